// ===== src/cal_pkg.sv =====
// ---------------------------------------------------------------------------
// cal_pkg
// Shared types and constants of the connection admission limiter: request
// and response payloads, verdict codes, register indexes and the
// controller-to-datapath command and status groups.
// ---------------------------------------------------------------------------
package cal_pkg;

   localparam int CAL_CLIENT_SLOTS  = 64;
   localparam int CAL_STAMP_ENTRIES = 16;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_LIMIT      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PER_SOURCE_LIMIT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THROTTLE_SECONDS = 2'd2;

   localparam logic [6:0]  TOTAL_LIMIT_RESET      = 7'd64;
   localparam logic [6:0]  PER_SOURCE_LIMIT_RESET = 7'd4;
   localparam logic [15:0] THROTTLE_RESET         = 16'd15;
   localparam logic [15:0] DEFAULT_THROTTLE       = 16'd15;

   localparam logic OP_CONNECT = 1'b0;
   localparam logic OP_CLOSE   = 1'b1;

   typedef enum logic [2:0] {
      VERDICT_ACCEPT    = 3'd0,
      VERDICT_TOTAL     = 3'd1,
      VERDICT_PERSRC    = 3'd2,
      VERDICT_THROTTLED = 3'd3,
      VERDICT_CLOSED    = 3'd4,
      VERDICT_EMPTY     = 3'd5
   } verdict_type;

   typedef struct packed {
      logic        opcode;
      logic [31:0] source_addr;
      logic [31:0] now_seconds;
      logic [5:0]  slot_index;
   } req_type;

   typedef struct packed {
      verdict_type verdict;
      logic [5:0]  granted_slot;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic slot_step;
      logic stamp_step;
      logic refuse_emit;
      logic connect_emit;
      logic close_emit;
   } cmd_type;

   typedef struct packed {
      logic slot_done;
      logic stamp_done;
      logic refused;
      logic rsp_blocked;
   } sts_type;

endpackage

// ===== src/cal_datapath.sv =====
// ---------------------------------------------------------------------------
// cal_datapath
// Configuration registers, slot table, throttle stamp table, scan
// accumulators and the response register of the admission limiter.
// ---------------------------------------------------------------------------
module cal_datapath
   import cal_pkg::*;
#(
   parameter int CLIENT_SLOTS  = CAL_CLIENT_SLOTS,
   parameter int STAMP_ENTRIES = CAL_STAMP_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  csr_valid,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data
);

   localparam int SLOT_IW  = $clog2(CLIENT_SLOTS);
   localparam int SCNT_W   = $clog2(CLIENT_SLOTS + 1);
   localparam int SAME_W   = $clog2(CLIENT_SLOTS + 2);
   localparam int STAMP_IW = $clog2(STAMP_ENTRIES);
   localparam int TCNT_W   = $clog2(STAMP_ENTRIES + 1);

   logic [6:0]  total_limit_ff;
   logic [6:0]  per_source_limit_ff;
   logic [15:0] throttle_ff;

   req_type req_ff;

   logic [CLIENT_SLOTS-1:0] slot_valid_ff;
   logic [SCNT_W-1:0]       open_count_ff;
   logic [31:0]             slot_source_mem [CLIENT_SLOTS];
   logic [31:0]             slot_rd_ff;
   logic [SCNT_W-1:0]       slot_scan_ff;
   logic                    slot_pipe_ff;
   logic [SLOT_IW-1:0]      slot_pipe_idx_ff;
   logic                    slot_pipe_v_ff;
   logic [SAME_W-1:0]       same_ff;
   logic                    free_found_ff;
   logic [SLOT_IW-1:0]      free_idx_ff;

   logic [STAMP_ENTRIES-1:0] stamp_valid_ff;
   logic [31:0]              stamp_source_mem [STAMP_ENTRIES];
   logic [31:0]              stamp_time_mem [STAMP_ENTRIES];
   logic [31:0]              stamp_src_rd_ff;
   logic [31:0]              stamp_time_rd_ff;
   logic [TCNT_W-1:0]        stamp_scan_ff;
   logic                     stamp_pipe_ff;
   logic [STAMP_IW-1:0]      stamp_pipe_idx_ff;
   logic                     stamp_pipe_v_ff;
   logic                     match_found_ff;
   logic [STAMP_IW-1:0]      match_idx_ff;
   logic                     match_thr_ff;
   logic                     inv_found_ff;
   logic [STAMP_IW-1:0]      inv_idx_ff;
   logic                     stale_found_ff;
   logic [STAMP_IW-1:0]      stale_idx_ff;
   logic                     old_found_ff;
   logic [STAMP_IW-1:0]      old_idx_ff;
   logic [31:0]              old_age_ff;

   logic    rsp_valid_ff;
   rsp_type rsp_ff;

   logic [15:0]         ival;
   logic [31:0]         ival32;
   logic                slot_issue;
   logic [SLOT_IW-1:0]  slot_addr;
   logic                slot_hit;
   logic                stamp_issue;
   logic [STAMP_IW-1:0] stamp_addr;
   logic [31:0]         stamp_age;
   logic                stamp_stale;
   logic                stamp_hit;
   logic                total_full;
   logic                persrc_full;
   logic                throttled;
   logic [STAMP_IW-1:0] stamp_pick;
   logic [SLOT_IW-1:0]  close_addr;
   logic                close_ok;
   logic                accept;

   assign ival        = (throttle_ff == 16'd0) ? DEFAULT_THROTTLE : throttle_ff;
   assign ival32      = {16'd0, ival};
   assign slot_issue  = cmd.slot_step && (slot_scan_ff != SCNT_W'(CLIENT_SLOTS));
   assign slot_addr   = slot_scan_ff[SLOT_IW-1:0];
   assign slot_hit    = slot_pipe_v_ff && (slot_rd_ff == req_ff.source_addr);
   assign stamp_issue = cmd.stamp_step && (stamp_scan_ff != TCNT_W'(STAMP_ENTRIES));
   assign stamp_addr  = stamp_scan_ff[STAMP_IW-1:0];
   assign stamp_age   = req_ff.now_seconds - stamp_time_rd_ff;
   assign stamp_stale = stamp_age >= ival32;
   assign stamp_hit   = stamp_pipe_v_ff && (stamp_src_rd_ff == req_ff.source_addr);

   assign total_full  = (32'(open_count_ff) >= 32'(total_limit_ff)) || !free_found_ff;
   assign persrc_full = 32'(same_ff) > 32'(per_source_limit_ff);
   assign throttled   = match_found_ff && match_thr_ff;
   assign accept      = cmd.connect_emit && !throttled;

   always_comb begin
      if (match_found_ff) begin
         stamp_pick = match_idx_ff;
      end else if (inv_found_ff) begin
         stamp_pick = inv_idx_ff;
      end else if (stale_found_ff) begin
         stamp_pick = stale_idx_ff;
      end else begin
         stamp_pick = old_idx_ff;
      end
   end

   assign close_addr = SLOT_IW'(req_ff.slot_index);
   assign close_ok   = (32'(req_ff.slot_index) < 32'(CLIENT_SLOTS)) && slot_valid_ff[close_addr];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         total_limit_ff      <= TOTAL_LIMIT_RESET;
         per_source_limit_ff <= PER_SOURCE_LIMIT_RESET;
         throttle_ff         <= THROTTLE_RESET;
         slot_valid_ff       <= '0;
         open_count_ff       <= '0;
         stamp_valid_ff      <= '0;
         slot_scan_ff        <= '0;
         slot_pipe_ff        <= 1'b0;
         stamp_scan_ff       <= '0;
         stamp_pipe_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_TOTAL_LIMIT:      total_limit_ff      <= csr_wdata[6:0];
               CSR_PER_SOURCE_LIMIT: per_source_limit_ff <= csr_wdata[6:0];
               CSR_THROTTLE_SECONDS: throttle_ff         <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.load) begin
            slot_scan_ff  <= '0;
            slot_pipe_ff  <= 1'b0;
            stamp_scan_ff <= '0;
            stamp_pipe_ff <= 1'b0;
         end
         if (cmd.slot_step) begin
            slot_pipe_ff <= slot_issue;
            if (slot_issue) begin
               slot_scan_ff <= slot_scan_ff + 1'b1;
            end
         end
         if (cmd.stamp_step) begin
            stamp_pipe_ff <= stamp_issue;
            if (stamp_issue) begin
               stamp_scan_ff <= stamp_scan_ff + 1'b1;
            end
         end
         if (accept) begin
            slot_valid_ff[free_idx_ff] <= 1'b1;
            open_count_ff              <= open_count_ff + 1'b1;
            stamp_valid_ff[stamp_pick] <= 1'b1;
         end
         if (cmd.close_emit && close_ok) begin
            slot_valid_ff[close_addr] <= 1'b0;
            if (open_count_ff != '0) begin
               open_count_ff <= open_count_ff - 1'b1;
            end
         end
         if (cmd.refuse_emit || cmd.connect_emit || cmd.close_emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // scan accumulators and payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff         <= req_data;
         same_ff        <= SAME_W'(1);
         free_found_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         inv_found_ff   <= 1'b0;
         stale_found_ff <= 1'b0;
         old_found_ff   <= 1'b0;
      end
      if (slot_issue) begin
         slot_pipe_idx_ff <= slot_addr;
         slot_pipe_v_ff   <= slot_valid_ff[slot_addr];
      end
      if (cmd.slot_step && slot_pipe_ff) begin
         if (slot_pipe_v_ff) begin
            if (slot_hit) begin
               same_ff <= same_ff + 1'b1;
            end
         end else if (!free_found_ff) begin
            free_found_ff <= 1'b1;
            free_idx_ff   <= slot_pipe_idx_ff;
         end
      end
      if (stamp_issue) begin
         stamp_pipe_idx_ff <= stamp_addr;
         stamp_pipe_v_ff   <= stamp_valid_ff[stamp_addr];
      end
      if (cmd.stamp_step && stamp_pipe_ff) begin
         if (stamp_hit && !match_found_ff) begin
            match_found_ff <= 1'b1;
            match_idx_ff   <= stamp_pipe_idx_ff;
            match_thr_ff   <= !stamp_stale;
         end
         if (!stamp_pipe_v_ff && !inv_found_ff) begin
            inv_found_ff <= 1'b1;
            inv_idx_ff   <= stamp_pipe_idx_ff;
         end
         if (stamp_pipe_v_ff && stamp_stale && !stale_found_ff) begin
            stale_found_ff <= 1'b1;
            stale_idx_ff   <= stamp_pipe_idx_ff;
         end
         if (stamp_pipe_v_ff && (!old_found_ff || (stamp_age > old_age_ff))) begin
            old_found_ff <= 1'b1;
            old_idx_ff   <= stamp_pipe_idx_ff;
            old_age_ff   <= stamp_age;
         end
      end
      if (cmd.refuse_emit) begin
         rsp_ff.verdict      <= total_full ? VERDICT_TOTAL : VERDICT_PERSRC;
         rsp_ff.granted_slot <= 6'd0;
      end else if (cmd.connect_emit) begin
         rsp_ff.verdict      <= throttled ? VERDICT_THROTTLED : VERDICT_ACCEPT;
         rsp_ff.granted_slot <= throttled ? 6'd0 : 6'(free_idx_ff);
      end else if (cmd.close_emit) begin
         rsp_ff.verdict      <= close_ok ? VERDICT_CLOSED : VERDICT_EMPTY;
         rsp_ff.granted_slot <= req_ff.slot_index;
      end
   end

   // slot source memory
   always_ff @(posedge clock) begin
      if (accept) begin
         slot_source_mem[free_idx_ff] <= req_ff.source_addr;
      end
      if (slot_issue) begin
         slot_rd_ff <= slot_source_mem[slot_addr];
      end
   end

   // stamp memories
   always_ff @(posedge clock) begin
      if (accept) begin
         stamp_source_mem[stamp_pick] <= req_ff.source_addr;
         stamp_time_mem[stamp_pick]   <= req_ff.now_seconds;
      end
      if (stamp_issue) begin
         stamp_src_rd_ff  <= stamp_source_mem[stamp_addr];
         stamp_time_rd_ff <= stamp_time_mem[stamp_addr];
      end
   end

   assign sts.slot_done   = (slot_scan_ff == SCNT_W'(CLIENT_SLOTS)) && !slot_pipe_ff;
   assign sts.stamp_done  = (stamp_scan_ff == TCNT_W'(STAMP_ENTRIES)) && !stamp_pipe_ff;
   assign sts.refused     = total_full || persrc_full;
   assign sts.rsp_blocked = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== src/cal_controller.sv =====
// ---------------------------------------------------------------------------
// cal_controller
// Sequencer of the admission limiter: accepts a request, runs the slot and
// stamp scans and issues the commit and response commands.
// ---------------------------------------------------------------------------
module cal_controller
   import cal_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_opcode,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLOSE,
      ST_SLOT,
      ST_CHECK,
      ST_STAMP,
      ST_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = (req_opcode == OP_CLOSE) ? ST_CLOSE : ST_SLOT;
            end
         end
         ST_CLOSE: begin
            if (!sts.rsp_blocked) begin
               cmd.close_emit = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_SLOT: begin
            if (sts.slot_done) begin
               state_in = ST_CHECK;
            end else begin
               cmd.slot_step = 1'b1;
            end
         end
         ST_CHECK: begin
            if (!sts.refused) begin
               state_in = ST_STAMP;
            end else if (!sts.rsp_blocked) begin
               cmd.refuse_emit = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_STAMP: begin
            if (sts.stamp_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.stamp_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!sts.rsp_blocked) begin
               cmd.connect_emit = 1'b1;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

// ===== src/connection_admission_limiter.sv =====
// ---------------------------------------------------------------------------
// connection_admission_limiter
// Admits or refuses connect requests against a total slot limit, a
// per-source slot limit and a per-source reconnect throttle; releases slots
// on close.
// ---------------------------------------------------------------------------
// A close request passes through ST_CLOSE, which registers its response once
// the response register is not blocked. A connect request scans the slot
// table one entry per cycle through its single read port and then the stamp
// table the same way before ST_FINISH registers its response; a refusal on
// the slot limits skips the stamp scan. One request is worked on at a time;
// the response register lets the next request in while a response waits.
// Configuration registers are written with csr_ready always high and may be
// written only while no request is in flight. No clearing pass after reset.
module connection_admission_limiter
   import cal_pkg::*;
#(
   parameter int CLIENT_SLOTS  = CAL_CLIENT_SLOTS,
   parameter int STAMP_ENTRIES = CAL_STAMP_ENTRIES
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   cal_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_data.opcode),
      .req_stall  (req_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   cal_datapath #(
      .CLIENT_SLOTS  (CLIENT_SLOTS),
      .STAMP_ENTRIES (STAMP_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted but controller not busy");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response raised without a request in flight");

   a_refuse_reason: assert property (@(posedge clock) disable iff (reset)
      cmd.refuse_emit |-> sts.refused && !sts.rsp_blocked)
      else $error("refusal issued without a limit hit");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.slot_step, cmd.stamp_step,
                cmd.refuse_emit, cmd.connect_emit, cmd.close_emit}))
      else $error("more than one command in a cycle");
`endif

endmodule

// ===== dv/connection_admission_limiter_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// connection_admission_limiter_checker
// Watches the request, response and register channels of the admission
// limiter, keeps its own copy of the slot table, the throttle stamps and the
// limits, predicts the response of every accepted request and compares each
// accepted response, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module connection_admission_limiter_checker
   import cal_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  req_type               req_data,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  rsp_type               rsp_data,
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count
);

   logic        slot_open [CAL_CLIENT_SLOTS];
   logic [31:0] slot_owner[CAL_CLIENT_SLOTS];
   int          open_slots;

   logic        stamp_used [CAL_STAMP_ENTRIES];
   logic [31:0] stamp_owner[CAL_STAMP_ENTRIES];
   logic [31:0] stamp_when [CAL_STAMP_ENTRIES];

   logic [6:0]  lim_total;
   logic [6:0]  lim_source;
   logic [15:0] throttle_reg;

   rsp_type     pending_verdicts[$];

   function automatic rsp_type admit_or_release(input req_type r);
      rsp_type     res;
      int          i;
      int          same;
      int          free_slot;
      int          st;
      logic [31:0] ival;
      logic [31:0] age;
      logic [31:0] oldest_age;
      logic        throttled;
      ival = (throttle_reg == 16'd0) ? 32'(DEFAULT_THROTTLE) : 32'(throttle_reg);
      res.verdict = VERDICT_ACCEPT;
      res.granted_slot = 6'd0;
      if (r.opcode == OP_CLOSE) begin
         if (int'(r.slot_index) < CAL_CLIENT_SLOTS && slot_open[r.slot_index]) begin
            slot_open[r.slot_index] = 1'b0;
            if (open_slots > 0) open_slots--;
            res.verdict = VERDICT_CLOSED;
         end else begin
            res.verdict = VERDICT_EMPTY;
         end
         res.granted_slot = r.slot_index;
         return res;
      end
      same = 1;
      free_slot = -1;
      for (i = 0; i < CAL_CLIENT_SLOTS; i++) begin
         if (slot_open[i]) begin
            if (slot_owner[i] == r.source_addr) same++;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (open_slots >= int'(lim_total) || free_slot < 0) begin
         res.verdict = VERDICT_TOTAL;
      end else if (same > int'(lim_source)) begin
         res.verdict = VERDICT_PERSRC;
      end else begin
         st = -1;
         for (i = 0; i < CAL_STAMP_ENTRIES; i++)
            if (st < 0 && stamp_used[i] && stamp_owner[i] == r.source_addr) st = i;
         throttled = 1'b0;
         if (st >= 0) begin
            age = r.now_seconds - stamp_when[st];
            throttled = (age < ival);
         end
         if (throttled) begin
            res.verdict = VERDICT_THROTTLED;
         end else begin
            slot_open[free_slot] = 1'b1;
            slot_owner[free_slot] = r.source_addr;
            open_slots++;
            // stamp choice: own entry, free entry, stale entry, oldest entry
            if (st < 0)
               for (i = 0; i < CAL_STAMP_ENTRIES; i++)
                  if (st < 0 && !stamp_used[i]) st = i;
            if (st < 0)
               for (i = 0; i < CAL_STAMP_ENTRIES; i++) begin
                  age = r.now_seconds - stamp_when[i];
                  if (st < 0 && age >= ival) st = i;
               end
            if (st < 0) begin
               st = 0;
               oldest_age = r.now_seconds - stamp_when[0];
               for (i = 1; i < CAL_STAMP_ENTRIES; i++) begin
                  age = r.now_seconds - stamp_when[i];
                  if (age > oldest_age) begin
                     st = i;
                     oldest_age = age;
                  end
               end
            end
            stamp_used[st] = 1'b1;
            stamp_owner[st] = r.source_addr;
            stamp_when[st] = r.now_seconds;
            res.verdict = VERDICT_ACCEPT;
            res.granted_slot = 6'(free_slot);
         end
      end
      return res;
   endfunction

   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < CAL_CLIENT_SLOTS; i++) slot_open[i] = 1'b0;
         for (int i = 0; i < CAL_STAMP_ENTRIES; i++) stamp_used[i] = 1'b0;
         open_slots = 0;
         lim_total = TOTAL_LIMIT_RESET;
         lim_source = PER_SOURCE_LIMIT_RESET;
         throttle_reg = THROTTLE_RESET;
         pending_verdicts.delete();
         error_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_TOTAL_LIMIT:      lim_total = csr_wdata[6:0];
               CSR_PER_SOURCE_LIMIT: lim_source = csr_wdata[6:0];
               CSR_THROTTLE_SECONDS: throttle_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_verdicts.size() == 0) begin
               $error("unexpected response: verdict %0d, granted_slot %0d",
                      rsp_data.verdict, rsp_data.granted_slot);
               error_count++;
            end else begin
               exp_rsp = pending_verdicts.pop_front();
               if (rsp_data.verdict !== exp_rsp.verdict) begin
                  $error("verdict: expected %0d, actual %0d",
                         exp_rsp.verdict, rsp_data.verdict);
                  error_count++;
               end
               if (rsp_data.granted_slot !== exp_rsp.granted_slot) begin
                  $error("granted_slot: expected %0d, actual %0d",
                         exp_rsp.granted_slot, rsp_data.granted_slot);
                  error_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            pending_verdicts = {pending_verdicts, admit_or_release(req_data)};
      end
      pending_count = pending_verdicts.size();
   end

endmodule

// ===== dv/connection_admission_limiter_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// connection_admission_limiter_test
// Drives connect and close requests and register writes into the admission
// limiter: a directed pass over limits, throttle wrap and empty closes, then
// random phases under several limit settings with random idling on both
// sides and one long response hold-off. The checker predicts and compares.
// ---------------------------------------------------------------------------
module connection_admission_limiter_test;
   import cal_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;
   localparam int SOURCE_POOL    = 20;
   localparam int DRAIN_CYCLES   = 120;
   localparam int HOLD_CYCLES    = 600;
   localparam int WATCHDOG_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   req_type               req_data;
   logic                  rsp_valid;
   logic                  rsp_stall;
   rsp_type               rsp_data;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    error_count;
   int                    pending_count;

   int                    send_idle_pct;
   int                    recv_idle_pct;
   logic                  hold_pending;
   int                    quiet_cycles;
   logic [31:0]           source_pool[SOURCE_POOL];
   logic [31:0]           wall_clock;

   connection_admission_limiter DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   connection_admission_limiter_checker CHECK (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // response side: random stall, plus one long hold-off on request
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_connect(input logic [31:0] src, input logic [31:0] now);
      req_type r;
      r.opcode = OP_CONNECT;
      r.source_addr = src;
      r.now_seconds = now;
      r.slot_index = 6'($urandom);
      send_request(r);
   endtask

   task automatic send_close(input logic [5:0] idx);
      req_type r;
      r.opcode = OP_CLOSE;
      r.source_addr = $urandom;
      r.now_seconds = $urandom;
      r.slot_index = idx;
      send_request(r);
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [6:0] total, input logic [6:0] per_src,
                            input logic [15:0] thr);
      csr_write(CSR_TOTAL_LIMIT, {9'($urandom), total});
      csr_write(CSR_PER_SOURCE_LIMIT, {9'($urandom), per_src});
      csr_write(CSR_THROTTLE_SECONDS, thr);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic random_requests(input int count, input int connect_pct,
                                  input int close_hi);
      int          n;
      int          roll;
      logic [31:0] src;
      for (n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         if (roll < 70) wall_clock += $urandom_range(8);
         else if (roll < 95) wall_clock += $urandom_range(40, 9);
         else wall_clock += $urandom;
         if ($urandom_range(99) < connect_pct) begin
            if ($urandom_range(9) == 0) src = $urandom;
            else src = source_pool[$urandom_range(SOURCE_POOL - 1)];
            send_connect(src, wall_clock);
         end else if ($urandom_range(4) == 0) begin
            send_close(6'($urandom_range(63)));
         end else begin
            send_close(6'($urandom_range(close_hi)));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      hold_pending = 1'b0;
      send_idle_pct = 13;
      recv_idle_pct = 63;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_wdata <= '0;
      source_pool[0] = 32'h0000_0000;
      source_pool[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < SOURCE_POOL; i++) source_pool[i] = $urandom;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // throttle at reset defaults, wrap of the age, per-source limit
      send_connect(32'h0000_0000, 32'd0);
      send_connect(32'h0000_0000, 32'd14);
      send_connect(32'h0000_0000, 32'd15);
      send_connect(32'hFFFF_FFFF, 32'hFFFF_FFF8);
      send_connect(32'hFFFF_FFFF, 32'd6);
      send_connect(32'hFFFF_FFFF, 32'd7);
      send_close(6'd63);
      send_close(6'd1);
      send_close(6'd1);
      send_connect(32'h0000_0000, 32'd30);
      send_connect(32'h0000_0000, 32'd45);
      send_connect(32'h0000_0000, 32'd60);
      send_connect(32'h0000_0000, 32'd75);
      drain();
      configure(7'd0, 7'd4, 16'd15);
      send_connect(32'h1234_5678, 32'd100);
      drain();
      configure(7'd64, 7'd0, 16'd0);
      send_connect(32'h0A00_0001, 32'd150);
      drain();
      configure(7'd127, 7'd64, 16'd0);
      csr_write(CSR_UNMAPPED, 16'($urandom));
      csr_valid <= 1'b0;
      @(posedge clock);
      send_connect(32'h0A00_0001, 32'd200);
      send_connect(32'h0A00_0001, 32'd214);
      send_connect(32'h0A00_0001, 32'd215);
      drain();

      wall_clock = $urandom;
      configure(7'd64, 7'd4, 16'd15);
      hold_pending = 1'b1;
      random_requests(130, 60, 15);
      drain();

      send_idle_pct = 63;
      recv_idle_pct = 13;
      configure(7'd127, 7'd64, 16'd1);
      random_requests(130, 85, 63);
      drain();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      configure(7'd10, 7'd2, 16'd65535);
      random_requests(70, 65, 15);
      drain();
      configure(7'd50, 7'd1, 16'd0);
      random_requests(70, 60, 15);
      drain();

      if (error_count == 0 && pending_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
